FILE: hw/rtl/pfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared sizes and types for the Pareto front ranker.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_INDIVIDUALS = 64;
    localparam int NUM_OBJ         = 3;
    localparam int OBJ_W           = 32;
    localparam int IDX_W           = $clog2(MAX_INDIVIDUALS);
    localparam int CNT_W           = $clog2(MAX_INDIVIDUALS + 1);

    typedef logic [IDX_W-1:0]                idx_t;
    typedef logic [CNT_W-1:0]                cnt_t;
    typedef logic [MAX_INDIVIDUALS-1:0]      set_vec_t;
    typedef logic [NUM_OBJ-1:0][OBJ_W-1:0]   obj_vec_t;

endpackage

FILE: hw/rtl/pareto_front_ranker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_ranker
// Non-dominated sorting of a set of individuals with three objectives.
// ----------------------------------------------------------------------------
// Usage:
// Individuals arrive as input words (objective_one..three, last_of_set) on a
// valid/ready channel, one word per cycle while loading. Words past 64 are
// dropped and the set is flagged as overflowed. The word with last_of_set
// closes the set; the block then stops taking input and ranks the n held
// individuals. Dominance pass: for each row i the objective memory is read
// for every j, and the dominated-by row is written to the row memory.
// Peeling: each front is one scan of the row memory, one scan per front.
// Results then leave in load order, each word read only after the previous
// one is taken, with member_index, front_rank, set_overflowed and
// last_of_run. A stalled receiver simply holds the current word; nothing
// is lost. After the last word is taken the block returns to loading.
// Reset empties the set and clears the overflow flag; the memories need
// no clearing.
// ----------------------------------------------------------------------------
module pareto_front_ranker
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] objective_one,
    input  logic [31:0] objective_two,
    input  logic [31:0] objective_three,
    input  logic        last_of_set,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  member_index,
    output logic [5:0]  front_rank,
    output logic        set_overflowed,
    output logic        last_of_run
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_ROW_RD,
        S_ROW_CAP,
        S_COL_RD,
        S_COL_CMP,
        S_ROW_WR,
        S_PEEL_RD,
        S_PEEL_CHK,
        S_OUT_RD,
        S_OUT_SHOW,
        S_OUT_HOLD
    } state_t;

    state_t   state_reg;
    cnt_t     load_cnt_reg;
    cnt_t     n_reg;
    logic     ovf_reg;
    idx_t     i_reg;
    idx_t     j_reg;
    idx_t     rank_reg;
    obj_vec_t obj_i_reg;
    set_vec_t row_reg;
    set_vec_t assigned_reg;
    set_vec_t front_reg;
    logic     out_valid_reg;
    idx_t     member_index_reg;
    idx_t     front_rank_reg;
    logic     set_overflowed_reg;
    logic     last_of_run_reg;

    // Memories: objectives, dominated-by rows and ranks.
    obj_vec_t obj_mem [MAX_INDIVIDUALS];
    set_vec_t dom_mem [MAX_INDIVIDUALS];
    idx_t     rank_mem [MAX_INDIVIDUALS];
    obj_vec_t obj_rd_data;
    set_vec_t dom_rd_data;
    idx_t     rank_rd_data;

    logic     in_accept;
    logic     set_full;
    logic     obj_wr_en;
    obj_vec_t obj_wr_data;
    idx_t     obj_rd_addr;
    logic     dom_hit;
    logic     last_idx;
    logic     is_front;
    set_vec_t front_now;
    set_vec_t full_mask;

    assign in_ready   = (state_reg == S_LOAD);
    assign in_accept  = in_valid && in_ready;
    assign set_full   = (load_cnt_reg == cnt_t'(MAX_INDIVIDUALS));
    assign obj_wr_en  = in_accept && !set_full;
    assign obj_rd_addr = (state_reg == S_ROW_RD) ? i_reg : j_reg;
    assign last_idx   = ({1'b0, i_reg} == (n_reg - cnt_t'(1)));

    always_comb
    begin
        obj_wr_data    = '0;
        obj_wr_data[0] = objective_one[OBJ_W-1:0];
        obj_wr_data[1] = objective_two[OBJ_W-1:0];
        obj_wr_data[2] = objective_three[OBJ_W-1:0];
    end

    // Objective memory: written while loading, read during the pair scan.
    always_ff @(posedge clk)
    begin
        if (obj_wr_en)
        begin
            obj_mem[load_cnt_reg[IDX_W-1:0]] <= obj_wr_data;
        end
        obj_rd_data <= obj_mem[obj_rd_addr];
    end

    // Row memory: bit j of row i is set when j dominates i.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW_WR)
        begin
            dom_mem[i_reg] <= row_reg;
        end
        dom_rd_data <= dom_mem[i_reg];
    end

    // Rank memory.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PEEL_CHK) && is_front)
        begin
            rank_mem[i_reg] <= rank_reg;
        end
        rank_rd_data <= rank_mem[i_reg];
    end

    // Candidate j against the held row individual i.
    pfr_dom_cmp u_cmp (
        .cand_obj  (obj_rd_data),
        .ref_obj   (obj_i_reg),
        .dominates (dom_hit)
    );

    // An individual joins the current front when it is unranked and all
    // its dominators were ranked in earlier fronts.
    assign is_front = !assigned_reg[i_reg] && ((dom_rd_data & ~assigned_reg) == '0);

    always_comb
    begin
        front_now = front_reg;
        if (is_front)
        begin
            front_now[i_reg] = 1'b1;
        end
        for (int b = 0; b < MAX_INDIVIDUALS; b++)
        begin
            full_mask[b] = (cnt_t'(b) < n_reg);
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            assigned_reg  <= '0;
            front_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_accept)
                    begin
                        if (set_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + cnt_t'(1);
                        end
                        if (last_of_set)
                        begin
                            n_reg     <= set_full ? load_cnt_reg
                                                  : load_cnt_reg + cnt_t'(1);
                            i_reg     <= '0;
                            state_reg <= S_ROW_RD;
                        end
                    end
                end
                S_ROW_RD:
                begin
                    state_reg <= S_ROW_CAP;
                end
                S_ROW_CAP:
                begin
                    obj_i_reg <= obj_rd_data;
                    row_reg   <= '0;
                    j_reg     <= '0;
                    state_reg <= S_COL_RD;
                end
                S_COL_RD:
                begin
                    state_reg <= S_COL_CMP;
                end
                S_COL_CMP:
                begin
                    row_reg[j_reg] <= dom_hit;
                    if ({1'b0, j_reg} == (n_reg - cnt_t'(1)))
                    begin
                        state_reg <= S_ROW_WR;
                    end
                    else
                    begin
                        j_reg     <= j_reg + idx_t'(1);
                        state_reg <= S_COL_RD;
                    end
                end
                S_ROW_WR:
                begin
                    if (last_idx)
                    begin
                        i_reg        <= '0;
                        rank_reg     <= '0;
                        assigned_reg <= '0;
                        front_reg    <= '0;
                        state_reg    <= S_PEEL_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + idx_t'(1);
                        state_reg <= S_ROW_RD;
                    end
                end
                S_PEEL_RD:
                begin
                    state_reg <= S_PEEL_CHK;
                end
                S_PEEL_CHK:
                begin
                    front_reg <= front_now;
                    i_reg     <= last_idx ? '0 : i_reg + idx_t'(1);
                    if (!last_idx)
                    begin
                        state_reg <= S_PEEL_RD;
                    end
                    else if (((assigned_reg | front_now) == full_mask) || (front_now == '0))
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        assigned_reg <= assigned_reg | front_now;
                        front_reg    <= '0;
                        rank_reg     <= rank_reg + idx_t'(1);
                        state_reg    <= S_PEEL_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_SHOW;
                end
                S_OUT_SHOW:
                begin
                    member_index_reg   <= i_reg;
                    front_rank_reg     <= rank_rd_data;
                    set_overflowed_reg <= ovf_reg;
                    last_of_run_reg    <= last_idx;
                    out_valid_reg      <= 1'b1;
                    state_reg          <= S_OUT_HOLD;
                end
                S_OUT_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_idx)
                        begin
                            load_cnt_reg <= '0;
                            ovf_reg      <= 1'b0;
                            state_reg    <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + idx_t'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign member_index   = member_index_reg;
    assign front_rank     = front_rank_reg;
    assign set_overflowed = set_overflowed_reg;
    assign last_of_run    = last_of_run_reg;

`ifndef SYNTHESIS
    // Input is never taken while a result word is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result is pending");

    // The set never grows beyond capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= cnt_t'(MAX_INDIVIDUALS))
        else $error("loaded count exceeds capacity");

    // Every result names a member of the ranked set.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, member_index} < n_reg))
        else $error("result index outside the set");

    // The last word of a run sends the block back to loading.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_run) |=> in_ready)
        else $error("block did not return to loading");
`endif

endmodule

FILE: hw/rtl/pfr_dom_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_dom_cmp
// Dominance test: cand dominates ref when no objective of cand is greater
// and at least one is strictly less (signed compare, smaller is better).
// ----------------------------------------------------------------------------
module pfr_dom_cmp
    import pfr_pkg::*;
(
    input  obj_vec_t cand_obj,
    input  obj_vec_t ref_obj,
    output logic     dominates
);

    logic [NUM_OBJ-1:0] worse;
    logic [NUM_OBJ-1:0] better;

    // Per-objective signed compares are independent of each other.
    always_comb
    begin
        for (int k = 0; k < NUM_OBJ; k++)
        begin
            worse[k]  = $signed(cand_obj[k]) > $signed(ref_obj[k]);
            better[k] = $signed(cand_obj[k]) < $signed(ref_obj[k]);
        end
    end

    assign dominates = (worse == '0) && (better != '0);

endmodule
